@@ hw/rtl/glyph_text_page_blitter_top_assert.svh @@
// assertion macros for the glyph text page blitter
// expects clk and rst_n in the scope of every use
`ifndef GLYPH_TEXT_PAGE_BLITTER_TOP_ASSERT_SVH
`define GLYPH_TEXT_PAGE_BLITTER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GTPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GTPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GTPB_ASSERT_IMP(lbl, ante, cons, msg)
`define GTPB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/gtpb_pkg.sv @@
// shared constants, action codes and font rom for the glyph text page blitter
// no dependencies
`timescale 1ns / 1ps

package gtpb_pkg;

  // framebuffer geometry
  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // printable code range
  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // framebuffer byte address of a page and column
  function automatic logic [ADDR_W-1:0] frame_addr(input logic [2:0] pg,
                                                   input logic [7:0] col);
    frame_addr = ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  // one glyph, first column in the highest byte
  function automatic logic [39:0] glyph_row(input logic [6:0] idx);
    logic [39:0] r;
    unique case (idx)
      7'd0:  r = 40'h0000000000;
      7'd1:  r = 40'h00005F0000;
      7'd2:  r = 40'h0007000700;
      7'd3:  r = 40'h147F147F14;
      7'd4:  r = 40'h242A7F2A12;
      7'd5:  r = 40'h2313086462;
      7'd6:  r = 40'h3649562050;
      7'd7:  r = 40'h0008070300;
      7'd8:  r = 40'h001C224100;
      7'd9:  r = 40'h0041221C00;
      7'd10: r = 40'h2A1C7F1C2A;
      7'd11: r = 40'h08083E0808;
      7'd12: r = 40'h0080703000;
      7'd13: r = 40'h0808080808;
      7'd14: r = 40'h0000606000;
      7'd15: r = 40'h2010080402;
      7'd16: r = 40'h3E5149453E;
      7'd17: r = 40'h00427F4000;
      7'd18: r = 40'h7249494946;
      7'd19: r = 40'h2141494D33;
      7'd20: r = 40'h1814127F10;
      7'd21: r = 40'h2745454539;
      7'd22: r = 40'h3C4A494931;
      7'd23: r = 40'h4121110907;
      7'd24: r = 40'h3649494936;
      7'd25: r = 40'h464949291E;
      7'd26: r = 40'h0000140000;
      7'd27: r = 40'h0040340000;
      7'd28: r = 40'h0008142241;
      7'd29: r = 40'h1414141414;
      7'd30: r = 40'h0041221408;
      7'd31: r = 40'h0201590906;
      7'd32: r = 40'h3E415D594E;
      7'd33: r = 40'h7C1211127C;
      7'd34: r = 40'h7F49494936;
      7'd35: r = 40'h3E41414122;
      7'd36: r = 40'h7F4141413E;
      7'd37: r = 40'h7F49494941;
      7'd38: r = 40'h7F09090901;
      7'd39: r = 40'h3E41415173;
      7'd40: r = 40'h7F0808087F;
      7'd41: r = 40'h00417F4100;
      7'd42: r = 40'h2040413F01;
      7'd43: r = 40'h7F08142241;
      7'd44: r = 40'h7F40404040;
      7'd45: r = 40'h7F021C027F;
      7'd46: r = 40'h7F0408107F;
      7'd47: r = 40'h3E4141413E;
      7'd48: r = 40'h7F09090906;
      7'd49: r = 40'h3E4151215E;
      7'd50: r = 40'h7F09192946;
      7'd51: r = 40'h2649494932;
      7'd52: r = 40'h03017F0103;
      7'd53: r = 40'h3F4040403F;
      7'd54: r = 40'h1F2040201F;
      7'd55: r = 40'h3F4038403F;
      7'd56: r = 40'h6314081463;
      7'd57: r = 40'h0304780403;
      7'd58: r = 40'h6159494D43;
      7'd59: r = 40'h007F414141;
      7'd60: r = 40'h0204081020;
      7'd61: r = 40'h004141417F;
      7'd62: r = 40'h0402010204;
      7'd63: r = 40'h4040404040;
      7'd64: r = 40'h0003070800;
      7'd65: r = 40'h2054547840;
      7'd66: r = 40'h7F28444438;
      7'd67: r = 40'h3844444428;
      7'd68: r = 40'h384444287F;
      7'd69: r = 40'h3854545418;
      7'd70: r = 40'h00087E0902;
      7'd71: r = 40'h18A4A49C78;
      7'd72: r = 40'h7F08040478;
      7'd73: r = 40'h00447D4000;
      7'd74: r = 40'h2040403D00;
      7'd75: r = 40'h7F10284400;
      7'd76: r = 40'h00417F4000;
      7'd77: r = 40'h7C04780478;
      7'd78: r = 40'h7C08040478;
      7'd79: r = 40'h3844444438;
      7'd80: r = 40'hFC18242418;
      7'd81: r = 40'h18242418FC;
      7'd82: r = 40'h7C08040408;
      7'd83: r = 40'h4854545424;
      7'd84: r = 40'h04043F4424;
      7'd85: r = 40'h3C4040207C;
      7'd86: r = 40'h1C2040201C;
      7'd87: r = 40'h3C4030403C;
      7'd88: r = 40'h4428102844;
      7'd89: r = 40'h4C9090907C;
      7'd90: r = 40'h4464544C44;
      7'd91: r = 40'h0008364100;
      7'd92: r = 40'h0000770000;
      7'd93: r = 40'h0041360800;
      7'd94: r = 40'h0201020402;
      default: r = 40'h0000000000;
    endcase
    glyph_row = r;
  endfunction

  // column k of a glyph; the spacing column and beyond are blank
  function automatic logic [7:0] glyph_col(input logic [39:0] row,
                                           input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = row[39:32];
      3'd1:    c = row[31:24];
      3'd2:    c = row[23:16];
      3'd3:    c = row[15:8];
      3'd4:    c = row[7:0];
      default: c = 8'h00;
    endcase
    glyph_col = c;
  endfunction

endpackage

@@ hw/rtl/gtpb_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gtpb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/glyph_text_page_blitter_top.sv @@
// glyph text page blitter: renders 5-column font text into a paged framebuffer
// depends on gtpb_pkg, gtpb_ram and glyph_text_page_blitter_top_assert.svh
// results: begin, skipped character and unknown items register their result on acceptance;
//   a read first passes through S_READ for one memory read, then registers its result
// a character takes one slot per column and page touched through the single ram,
//   then S_FLUSH: up to 6 columns x 2 pages, with in_tready low until back in S_IDLE
// reset: after rst_n rises, a clearing pass writes zero to all PAGES*COLUMNS bytes
//   with in_tready low; dirty flags and cursor reset to zero
`timescale 1ns / 1ps
`include "glyph_text_page_blitter_top_assert.svh"

module glyph_text_page_blitter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_x[7:0], start_y[13:8], char_code[21:14], more_follows[22],
  // read_page[25:23], read_column[32:26], zero[39:33]
  input  logic [39:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_x[7:0], read_data[15:8], page_dirty[16], zero[23:17]
  output logic [23:0] out_tdata
);

  localparam int AW = gtpb_pkg::ADDR_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DRAW  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [7:0]  cursor_r, cursor_nxt;
  logic [2:0]  page_r, page_nxt;
  logic [2:0]  shift_r, shift_nxt;
  logic [7:0]  dirty_r, dirty_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        half_r, half_nxt;
  logic [39:0] glyph_r, glyph_nxt;
  logic        more_r, more_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  logic        rd_dirty_r, rd_dirty_nxt;
  logic        s2_we_r, s2_we_nxt;
  logic [AW-1:0] s2_addr_r, s2_addr_nxt;
  logic [7:0]  s2_g_r, s2_g_nxt;
  logic        s2_hi_r, s2_hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_cursor_r, out_cursor_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_dirty_r, out_dirty_nxt;

  // input fields
  gtpb_pkg::action_t f_action;
  logic [7:0] f_start_x;
  logic [5:0] f_start_y;
  logic [7:0] f_code;
  logic       f_more;
  logic [2:0] f_rpage;
  logic [6:0] f_rcol;

  assign f_action  = gtpb_pkg::action_t'(in_tuser);
  assign f_start_x = in_tdata[7:0];
  assign f_start_y = in_tdata[13:8];
  assign f_code    = in_tdata[21:14];
  assign f_more    = in_tdata[22];
  assign f_rpage   = in_tdata[25:23];
  assign f_rcol    = in_tdata[32:26];

  logic in_accept;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  // framebuffer memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  gtpb_ram #(
    .DEPTH (gtpb_pkg::DEPTH),
    .WIDTH (8),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // current draw slot: column k of the glyph on the upper or lower page
  logic [3:0]    pg_sel;
  logic          slot_we;
  logic [AW-1:0] slot_addr;
  logic          hi_needed;
  logic          last_col;
  logic [7:0]    slot_g;

  assign pg_sel    = half_r ? ({1'b0, page_r} + 4'd1) : {1'b0, page_r};
  assign slot_we   = pg_sel < 4'(gtpb_pkg::PAGES);
  assign slot_addr = gtpb_pkg::frame_addr(pg_sel[2:0], cursor_r);
  assign hi_needed = (shift_r != 3'd0) && (({1'b0, page_r} + 4'd1) < 4'(gtpb_pkg::PAGES));
  assign slot_g    = gtpb_pkg::glyph_col(glyph_r, k_r);
  assign last_col  = (({1'b0, cursor_r} + 9'd1) >= 9'(gtpb_pkg::COLUMNS)) ||
                     (k_r == 3'd5) || ((k_r == 3'd4) && !more_r);

  // merge of the glyph byte into the byte read back
  logic [15:0] wide_g;
  logic [7:0]  keep_lo, keep_hi, merged;

  assign wide_g  = 16'(s2_g_r) << shift_r;
  assign keep_hi = 8'hFF << shift_r;
  assign keep_lo = ~keep_hi;
  assign merged  = s2_hi_r ? ((mem_rdata & keep_hi) | wide_g[15:8])
                           : ((mem_rdata & keep_lo) | wide_g[7:0]);

  // printable test of the incoming code
  logic printable;
  assign printable = (f_code >= gtpb_pkg::CODE_FIRST) && (f_code <= gtpb_pkg::CODE_LAST);

  logic [7:0] code_ofs;
  assign code_ofs = f_code - gtpb_pkg::CODE_FIRST;

  // control and next-state logic
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cursor_nxt     = cursor_r;
    page_nxt       = page_r;
    shift_nxt      = shift_r;
    dirty_nxt      = dirty_r;
    k_nxt          = k_r;
    half_nxt       = half_r;
    glyph_nxt      = glyph_r;
    more_nxt       = more_r;
    rd_ok_nxt      = rd_ok_r;
    rd_dirty_nxt   = rd_dirty_r;
    s2_we_nxt      = 1'b0;
    s2_addr_nxt    = s2_addr_r;
    s2_g_nxt       = s2_g_r;
    s2_hi_nxt      = s2_hi_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cursor_nxt = out_cursor_r;
    out_data_nxt   = out_data_r;
    out_dirty_nxt  = out_dirty_r;
    mem_raddr      = slot_addr;
    mem_we         = s2_we_r;
    mem_waddr      = s2_addr_r;
    mem_wdata      = merged;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 8'h00;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(gtpb_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          unique case (f_action)
            gtpb_pkg::ACT_BEGIN: begin
              cursor_nxt = f_start_x;
              page_nxt   = f_start_y[5:3];
              shift_nxt  = f_start_y[2:0];
              if ({1'b0, f_start_y[5:3]} < 4'(gtpb_pkg::PAGES)) begin
                dirty_nxt[f_start_y[5:3]] = 1'b1;
              end
              if ((f_start_y[2:0] != 3'd0) &&
                  (({1'b0, f_start_y[5:3]} + 4'd1) < 4'(gtpb_pkg::PAGES))) begin
                dirty_nxt[f_start_y[5:3] + 3'd1] = 1'b1;
              end
              out_valid_nxt  = 1'b1;
              out_cursor_nxt = f_start_x;
              out_data_nxt   = 8'h00;
              out_dirty_nxt  = 1'b0;
            end
            gtpb_pkg::ACT_CHAR: begin
              if ((9'(cursor_r) < 9'(gtpb_pkg::COLUMNS)) && printable) begin
                glyph_nxt = gtpb_pkg::glyph_row(code_ofs[6:0]);
                more_nxt  = f_more;
                k_nxt     = 3'd0;
                half_nxt  = 1'b0;
                state_nxt = S_DRAW;
              end else begin
                out_valid_nxt  = 1'b1;
                out_cursor_nxt = cursor_r;
                out_data_nxt   = 8'h00;
                out_dirty_nxt  = 1'b0;
              end
            end
            gtpb_pkg::ACT_READ: begin
              mem_raddr    = gtpb_pkg::frame_addr(f_rpage, {1'b0, f_rcol});
              rd_ok_nxt    = ({1'b0, f_rpage} < 4'(gtpb_pkg::PAGES)) &&
                             (9'(f_rcol) < 9'(gtpb_pkg::COLUMNS));
              rd_dirty_nxt = dirty_r[f_rpage];
              state_nxt    = S_READ;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_cursor_nxt = cursor_r;
              out_data_nxt   = 8'h00;
              out_dirty_nxt  = 1'b0;
            end
          endcase
        end
      end

      // one slot a cycle: read now, merge and write back next cycle
      S_DRAW: begin
        s2_we_nxt   = slot_we;
        s2_addr_nxt = slot_addr;
        s2_g_nxt    = slot_g;
        s2_hi_nxt   = half_r;
        if (!half_r && hi_needed) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt   = 1'b0;
          cursor_nxt = cursor_r + 8'd1;
          k_nxt      = k_r + 3'd1;
          if (last_col) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      // last write back lands, result goes out
      S_FLUSH: begin
        out_valid_nxt  = 1'b1;
        out_cursor_nxt = cursor_r;
        out_data_nxt   = 8'h00;
        out_dirty_nxt  = 1'b0;
        state_nxt      = S_IDLE;
      end

      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_cursor_nxt = cursor_r;
        out_data_nxt   = rd_ok_r ? mem_rdata : 8'h00;
        out_dirty_nxt  = rd_dirty_r;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= 8'd0;
      page_r      <= 3'd0;
      shift_r     <= 3'd0;
      dirty_r     <= 8'd0;
      k_r         <= 3'd0;
      half_r      <= 1'b0;
      s2_we_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      page_r      <= page_nxt;
      shift_r     <= shift_nxt;
      dirty_r     <= dirty_nxt;
      k_r         <= k_nxt;
      half_r      <= half_nxt;
      s2_we_r     <= s2_we_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    glyph_r      <= glyph_nxt;
    more_r       <= more_nxt;
    rd_ok_r      <= rd_ok_nxt;
    rd_dirty_r   <= rd_dirty_nxt;
    s2_addr_r    <= s2_addr_nxt;
    s2_g_r       <= s2_g_nxt;
    s2_hi_r      <= s2_hi_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_data_r   <= out_data_nxt;
    out_dirty_r  <= out_dirty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_dirty_r, out_data_r, out_cursor_r};

  // checks
  `GTPB_ASSERT_IMP(a_draw_out_empty, state_r == S_DRAW, !out_valid_r, "result slot busy while drawing")
  `GTPB_ASSERT_NXT(a_flush_result, state_r == S_FLUSH, out_valid_r && (state_r == S_IDLE), "character result missing after flush")
  `GTPB_ASSERT_IMP(a_clear_no_draw, state_r == S_CLEAR, !s2_we_r, "draw write during clearing pass")
  `GTPB_ASSERT_NXT(a_hi_then_lo, (state_r == S_DRAW) && half_r, !half_r, "lower page slot not followed by next column")
  `GTPB_ASSERT_IMP(a_write_in_draw, s2_we_r, (state_r == S_DRAW) || (state_r == S_FLUSH), "write back outside a character")

endmodule
